// ===== rtl/phcd_pkg.sv =====
// ----------------------------------------------------------------------------
// phcd_pkg
// Shared types and constants for the position history click detector:
// operation codes, register indexes, reset values and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package phcd_pkg;

	localparam int FUNC_W      = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int TICK_W      = 32;
	localparam int BOUND_W     = 16;
	localparam int COUNT_OUT_W = 5;
	localparam int LANES       = 3;

	// lane order within a sample
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD   = 3'd0,
		FUNC_CLEAR = 3'd1,
		FUNC_FILL  = 3'd2,
		FUNC_CLICK = 3'd3,
		FUNC_TICK  = 3'd4
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HOLDOFF    = 2'd0,
		CFG_CLICK_LOW  = 2'd1,
		CFG_CLICK_HIGH = 2'd2
	} cfg_index_t;

	localparam logic [TICK_W-1:0]         HOLDOFF_RESET    = 32'd500;
	localparam logic signed [BOUND_W-1:0] CLICK_LOW_RESET  = 16'sd25;
	localparam logic signed [BOUND_W-1:0] CLICK_HIGH_RESET = 16'sd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_OLD,
		ST_UPDATE,
		ST_SWEEP,
		ST_DIV_LOAD,
		ST_DIVIDE,
		ST_AVERAGE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic read_old;
		logic update;
		logic sweep;
		logic div_load;
		logic div_step;
		logic average;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic sweep_last;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/phcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// phcd_ctrl
// Sequencer for one item: optional read of the oldest slot or fill sweep,
// optional state update, serial division of the three sums, then click test and result.
// ----------------------------------------------------------------------------
module phcd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [phcd_pkg::FUNC_W-1:0]   func,
	input  phcd_pkg::status_t             status,
	output logic                          in_stall,
	output phcd_pkg::cmd_t                cmd
);

	phcd_pkg::state_t state_q;
	phcd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != phcd_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			phcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (func)
						phcd_pkg::FUNC_ADD: begin
							state_d = status.full ? phcd_pkg::ST_READ_OLD
							                      : phcd_pkg::ST_UPDATE;
						end
						phcd_pkg::FUNC_CLEAR: state_d = phcd_pkg::ST_UPDATE;
						phcd_pkg::FUNC_FILL:  state_d = phcd_pkg::ST_SWEEP;
						default:              state_d = phcd_pkg::ST_DIV_LOAD;
					endcase
				end
			end
			phcd_pkg::ST_READ_OLD: begin
				cmd.read_old = 1'b1;
				state_d      = phcd_pkg::ST_UPDATE;
			end
			phcd_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = phcd_pkg::ST_UPDATE;
				end
			end
			phcd_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = phcd_pkg::ST_DIV_LOAD;
			end
			phcd_pkg::ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = phcd_pkg::ST_DIVIDE;
			end
			phcd_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = phcd_pkg::ST_AVERAGE;
				end
			end
			phcd_pkg::ST_AVERAGE: begin
				cmd.average = 1'b1;
				state_d     = phcd_pkg::ST_FINISH;
			end
			phcd_pkg::ST_FINISH: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = phcd_pkg::ST_IDLE;
				end
			end
			default: state_d = phcd_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/phcd_datapath.sv =====
// ----------------------------------------------------------------------------
// phcd_datapath
// History ring store, running sums, fill count, three-lane serial divider,
// click test with holdoff, configuration registers and the output register.
// ----------------------------------------------------------------------------
module phcd_datapath #(
	parameter int HISTORY_LENGTH = 16,
	parameter int COORD_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  phcd_pkg::cmd_t                      cmd,
	output phcd_pkg::status_t                   status,
	input  logic                                cfg_write_en,
	input  logic [phcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [phcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [phcd_pkg::FUNC_W-1:0]         func,
	input  logic signed [COORD_BITS-1:0]        sample_x,
	input  logic signed [COORD_BITS-1:0]        sample_y,
	input  logic signed [COORD_BITS-1:0]        sample_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        smooth_x,
	output logic signed [COORD_BITS-1:0]        smooth_y,
	output logic signed [COORD_BITS-1:0]        smooth_z,
	output logic                                click,
	output logic [phcd_pkg::COUNT_OUT_W-1:0]    history_count
);

	localparam int SUM_W  = COORD_BITS + $clog2(HISTORY_LENGTH);
	localparam int CNT_W  = $clog2(HISTORY_LENGTH + 1);
	localparam int SLOT_W = (HISTORY_LENGTH > 1) ? $clog2(HISTORY_LENGTH) : 1;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int WORD_W = phcd_pkg::LANES * COORD_BITS;
	localparam int DIF_W  = (COORD_BITS >= phcd_pkg::BOUND_W) ? COORD_BITS + 1
	                                                         : phcd_pkg::BOUND_W + 1;
	localparam int LANES  = phcd_pkg::LANES;

	localparam logic [SLOT_W-1:0]       LAST_SLOT  = SLOT_W'(HISTORY_LENGTH - 1);
	localparam logic [CNT_W-1:0]        FULL_COUNT = CNT_W'(HISTORY_LENGTH);
	localparam logic signed [SUM_W-1:0] HIST_LEN_S = SUM_W'(HISTORY_LENGTH);
	localparam logic [STEP_W-1:0]       LAST_STEP  = STEP_W'(SUM_W - 1);

	// captured item
	logic [phcd_pkg::FUNC_W-1:0]  func_q;
	logic signed [COORD_BITS-1:0] sample_q [LANES];

	// history state
	logic [WORD_W-1:0]            mem_q [HISTORY_LENGTH];
	logic [WORD_W-1:0]            rd_q;
	logic signed [SUM_W-1:0]      sum_q [LANES];
	logic [CNT_W-1:0]             count_q;
	logic [SLOT_W-1:0]            slot_q;
	logic [SLOT_W-1:0]            sweep_q;
	logic [phcd_pkg::TICK_W-1:0]  ticks_q;

	// configuration
	logic [phcd_pkg::TICK_W-1:0]         holdoff_q;
	logic signed [phcd_pkg::BOUND_W-1:0] click_low_q;
	logic signed [phcd_pkg::BOUND_W-1:0] click_high_q;

	// divider lanes
	logic [SUM_W-1:0]             dq_q  [LANES];
	logic [CNT_W-1:0]             rem_q [LANES];
	logic [LANES-1:0]             neg_q;
	logic [STEP_W-1:0]            step_q;
	logic signed [COORD_BITS-1:0] avg_q [LANES];

	// output register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] out_avg_q [LANES];
	logic                         click_q;
	logic [CNT_W-1:0]             out_count_q;

	logic                         full;
	logic [SLOT_W-1:0]            next_slot;
	logic [WORD_W-1:0]            sample_word;
	logic signed [SUM_W-1:0]      add_sum [LANES];
	logic signed [SUM_W-1:0]      fill_sum [LANES];
	logic [CNT_W:0]               trial [LANES];
	logic                         trial_ge [LANES];
	logic signed [DIF_W-1:0]      dif;
	logic                         click_fire;
	logic                         is_click;
	logic                         is_tick;

	assign full      = (count_q == FULL_COUNT);
	assign next_slot = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sample_word[l*COORD_BITS +: COORD_BITS] = sample_q[l];
			add_sum[l] = sum_q[l] + SUM_W'(sample_q[l])
				- (full ? SUM_W'($signed(rd_q[l*COORD_BITS +: COORD_BITS])) : '0);
			fill_sum[l] = SUM_W'(sample_q[l]) * HIST_LEN_S;
			trial[l]    = {rem_q[l], dq_q[l][SUM_W-1]};
			trial_ge[l] = (trial[l] >= {1'b0, count_q});
		end
	end

	assign dif = DIF_W'(avg_q[phcd_pkg::LANE_Y]) - DIF_W'(sample_q[phcd_pkg::LANE_Y]);
	assign is_click   = (func_q == phcd_pkg::FUNC_CLICK);
	assign is_tick    = (func_q == phcd_pkg::FUNC_TICK);
	assign click_fire = is_click && (ticks_q > holdoff_q)
		&& (dif > DIF_W'(click_low_q)) && (dif < DIF_W'(click_high_q));

	assign status.full       = full;
	assign status.sweep_last = (sweep_q == LAST_SLOT);
	assign status.div_last   = (step_q == LAST_STEP);
	assign status.out_free   = !out_valid_q || !out_stall;

	// captured item and divider working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q               <= func;
			sample_q[phcd_pkg::LANE_X] <= sample_x;
			sample_q[phcd_pkg::LANE_Y] <= sample_y;
			sample_q[phcd_pkg::LANE_Z] <= sample_z;
		end
		if (cmd.div_load) begin
			step_q <= '0;
			for (int l = 0; l < LANES; l++) begin
				neg_q[l] <= sum_q[l][SUM_W-1];
				dq_q[l]  <= sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);
				rem_q[l] <= '0;
			end
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
			for (int l = 0; l < LANES; l++) begin
				// shift the dividend out, the quotient bit in
				dq_q[l]  <= {dq_q[l][SUM_W-2:0], trial_ge[l]};
				rem_q[l] <= trial_ge[l] ? CNT_W'(trial[l] - {1'b0, count_q})
				                        : CNT_W'(trial[l]);
			end
		end
		if (cmd.average) begin
			for (int l = 0; l < LANES; l++) begin
				if (count_q == '0) begin
					avg_q[l] <= '0;
				end else if (neg_q[l]) begin
					avg_q[l] <= -$signed(dq_q[l][COORD_BITS-1:0]);
				end else begin
					avg_q[l] <= $signed(dq_q[l][COORD_BITS-1:0]);
				end
			end
		end
	end

	// history store
	always_ff @(posedge clk) begin
		if (cmd.read_old) begin
			rd_q <= mem_q[next_slot];
		end
		if (cmd.sweep) begin
			mem_q[sweep_q] <= sample_word;
		end else if (cmd.update && func_q == phcd_pkg::FUNC_ADD) begin
			mem_q[next_slot] <= sample_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	// sums, count, write slot, tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				sum_q[l] <= '0;
			end
			count_q <= '0;
			slot_q  <= LAST_SLOT;
			ticks_q <= '0;
		end else begin
			if (cmd.update) begin
				case (func_q)
					phcd_pkg::FUNC_ADD: begin
						for (int l = 0; l < LANES; l++) begin
							sum_q[l] <= add_sum[l];
						end
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
						slot_q <= next_slot;
					end
					phcd_pkg::FUNC_CLEAR: begin
						for (int l = 0; l < LANES; l++) begin
							sum_q[l] <= '0;
						end
						count_q <= '0;
						slot_q  <= LAST_SLOT;
					end
					phcd_pkg::FUNC_FILL: begin
						for (int l = 0; l < LANES; l++) begin
							sum_q[l] <= fill_sum[l];
						end
						count_q <= FULL_COUNT;
						slot_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.finish) begin
				if (click_fire) begin
					ticks_q <= '0;
				end else if (is_tick && ticks_q != '1) begin
					ticks_q <= ticks_q + 1'b1;
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q    <= phcd_pkg::HOLDOFF_RESET;
			click_low_q  <= phcd_pkg::CLICK_LOW_RESET;
			click_high_q <= phcd_pkg::CLICK_HIGH_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				phcd_pkg::CFG_HOLDOFF:    holdoff_q    <= cfg_data[phcd_pkg::TICK_W-1:0];
				phcd_pkg::CFG_CLICK_LOW:  click_low_q  <= $signed(cfg_data[phcd_pkg::BOUND_W-1:0]);
				phcd_pkg::CFG_CLICK_HIGH: click_high_q <= $signed(cfg_data[phcd_pkg::BOUND_W-1:0]);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int l = 0; l < LANES; l++) begin
				out_avg_q[l] <= avg_q[l];
			end
			click_q     <= click_fire;
			out_count_q <= count_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign smooth_x      = out_avg_q[phcd_pkg::LANE_X];
	assign smooth_y      = out_avg_q[phcd_pkg::LANE_Y];
	assign smooth_z      = out_avg_q[phcd_pkg::LANE_Z];
	assign click         = click_q;
	assign history_count = phcd_pkg::COUNT_OUT_W'(out_count_q);

endmodule

// ===== rtl/position_history_click_detector_core.sv =====
// ----------------------------------------------------------------------------
// position_history_click_detector_core
// Moving average of a tracked 3D cursor over the last HISTORY_LENGTH samples,
// with a click test on smoothed y against a ray y. One result per item.
// The block works on one item at a time. Tick, click test and unused codes
// run the divider load, division, averaging and finish steps; add and clear
// put a state update before them, an add into a full history also reads the
// oldest slot first, and fill sweeps the history store before its update.
// The serial divider produces one quotient bit per cycle over SUM_W =
// COORD_BITS + clog2(HISTORY_LENGTH) bits for all three averages at once,
// and the fill sweep writes one slot per cycle. A finished result waits in
// the output register while the next item is already being worked on.
// ----------------------------------------------------------------------------
module position_history_click_detector_core #(
	parameter int HISTORY_LENGTH = 16,
	parameter int COORD_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [phcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [phcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [phcd_pkg::FUNC_W-1:0]         func,
	input  logic signed [COORD_BITS-1:0]        sample_x,
	input  logic signed [COORD_BITS-1:0]        sample_y,
	input  logic signed [COORD_BITS-1:0]        sample_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        smooth_x,
	output logic signed [COORD_BITS-1:0]        smooth_y,
	output logic signed [COORD_BITS-1:0]        smooth_z,
	output logic                                click,
	output logic [phcd_pkg::COUNT_OUT_W-1:0]    history_count
);

	phcd_pkg::cmd_t    cmd;
	phcd_pkg::status_t status;

	phcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	phcd_datapath #(
		.HISTORY_LENGTH (HISTORY_LENGTH),
		.COORD_BITS     (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.sample_x      (sample_x),
		.sample_y      (sample_y),
		.sample_z      (sample_z),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.smooth_x      (smooth_x),
		.smooth_y      (smooth_y),
		.smooth_z      (smooth_z),
		.click         (click),
		.history_count (history_count)
	);

endmodule

// ===== rtl/phcd_checker.sv =====
// ----------------------------------------------------------------------------
// phcd_checker
// Port-level checks for the click detector core, bound to the top level.
// ----------------------------------------------------------------------------
module phcd_checker #(
	parameter int HISTORY_LENGTH = 16,
	parameter int COORD_BITS     = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [COORD_BITS-1:0]        smooth_x,
	input logic signed [COORD_BITS-1:0]        smooth_y,
	input logic signed [COORD_BITS-1:0]        smooth_z,
	input logic                                click,
	input logic [phcd_pkg::COUNT_OUT_W-1:0]    history_count
);

	// a waiting result is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(smooth_x) && $stable(smooth_y)
			&& $stable(smooth_z) && $stable(click) && $stable(history_count))
		else $error("stalled result changed");

	// an accepted item keeps the block busy, so the input is not taken again too soon
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again too soon");

	// the reported count never exceeds the history length
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (HISTORY_LENGTH > 31)
			|| (history_count <= phcd_pkg::COUNT_OUT_W'(HISTORY_LENGTH)))
		else $error("history count out of range");

endmodule

bind position_history_click_detector_core phcd_checker #(
	.HISTORY_LENGTH (HISTORY_LENGTH),
	.COORD_BITS     (COORD_BITS)
) u_phcd_checker (.*);
